[rtl/base64_stream_encoder_assert.svh]
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define B64E_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// next-cycle implication, checked out of reset
`define B64E_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

[rtl/b64e_pkg.sv]
`default_nettype none

package b64e_pkg;

    localparam int MAX_CHARS   = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [5:0] sym_t;
    typedef logic [6:0] char_t;
    typedef logic [2:0] char_cnt_t;

    localparam char_t PAD_CHAR = 7'd61;

    typedef struct packed {
        char_t [MAX_CHARS-1:0] chars;
        char_cnt_t             count;
        logic                  last;
    } job_t;

    function automatic char_t enc_symbol(input sym_t sym);
        char_t ch;
        ch = {1'b0, sym};
        if (sym < 6'd26)
        begin
            return ch + 7'd65;
        end
        else if (sym < 6'd52)
        begin
            return ch + 7'd71;
        end
        else if (sym < 6'd62)
        begin
            return ch - 7'd4;
        end
        else if (sym == 6'd62)
        begin
            return 7'd43;
        end
        else
        begin
            return 7'd47;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/b64e_front.sv]
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_message,
    output job_t            job
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;

    logic [3:0] carry_reg;
    logic [3:0] carry_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] carry_step;
    logic [1:0] phase_step;

    always_comb
    begin
        job.chars = {MAX_CHARS{PAD_CHAR}};
        job.count = 3'd1;
        job.last  = end_of_message;
        unique case (phase_reg)
            PH_ONE:
            begin
                job.chars[0] = enc_symbol({carry_reg[1:0], data_byte[7:4]});
                carry_step   = data_byte[3:0];
                phase_step   = PH_TWO;
            end
            PH_TWO:
            begin
                job.chars[0] = enc_symbol({carry_reg, data_byte[7:6]});
                job.chars[1] = enc_symbol(data_byte[5:0]);
                job.count    = 3'd2;
                carry_step   = 4'd0;
                phase_step   = PH_START;
            end
            default:
            begin
                job.chars[0] = enc_symbol(data_byte[7:2]);
                carry_step   = {2'b00, data_byte[1:0]};
                phase_step   = PH_ONE;
            end
        endcase
        carry_next = carry_step;
        phase_next = phase_step;
        if (end_of_message)
        begin
            if (phase_step == PH_ONE)
            begin
                job.chars[1] = enc_symbol({carry_step[1:0], 4'b0000});
                job.count    = 3'd4;
            end
            else if (phase_step == PH_TWO)
            begin
                job.chars[1] = enc_symbol({carry_step, 2'b00});
                job.count    = 3'd3;
            end
            carry_next = 4'd0;
            phase_next = PH_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 4'd0;
            phase_reg <= PH_START;
        end
        else if (accept)
        begin
            carry_reg <= carry_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

[rtl/b64e_queue.sv]
`default_nettype none

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_data,
    output logic      full,
    output logic      rd_valid,
    output job_t      rd_data,
    input  wire logic rd_en
);

    localparam int IdxW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    job_t            entries_reg [Depth];
    logic [IdxW-1:0] wr_ptr_reg;
    logic [IdxW-1:0] wr_ptr_next;
    logic [IdxW-1:0] rd_ptr_reg;
    logic [IdxW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_wr;
    logic            do_rd;

    assign full     = (count_reg == CntW'(Depth));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entries_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == IdxW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == IdxW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/b64e_back.sv]
`default_nettype none

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_valid,
    input  wire job_t       job,
    output logic            job_done,
    output logic [6:0]      code_char,
    output logic            last_char,
    output logic            empty,
    input  wire logic       pop
);

    logic       valid_reg;
    logic       valid_next;
    char_t      char_reg;
    char_t      char_next;
    logic       last_reg;
    logic       last_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       slot_free;
    logic       final_idx;

    assign slot_free = !valid_reg || pop;
    assign final_idx = ({1'b0, idx_reg} + 3'd1) == job.count;
    assign job_done  = slot_free && job_valid && final_idx;

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        if (slot_free)
        begin
            valid_next = job_valid;
            if (job_valid)
            begin
                char_next = job.chars[idx_reg];
                last_next = job.last && final_idx;
                idx_next  = final_idx ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign code_char = char_reg;
    assign last_char = last_reg;
    assign empty     = !valid_reg;

endmodule

`default_nettype wire

[rtl/base64_stream_encoder.sv]
// base64 stream encoder, standard alphabet with '=' padding
// input side: drive data_byte and end_of_message with push; a byte is taken
// on a clock edge where push is high and full is low. mark the final byte of
// each message with end_of_message
// result side: while empty is low, code_char and last_char show the oldest
// character; pop on a clock edge with empty low takes it. last_char marks
// the final character of the encoded message
// each byte yields one to four characters, which leave one per cycle from a
// registered output stage while pop is high; a byte's first character is
// visible only after it has passed the job queue and then the output register
// bytes are taken every cycle while the two-entry job queue has room, so the
// sustained rate is set by the single character output: about 4/3 characters
// per byte in a message body, up to four characters for a final byte
// reset clears the group position, the carried bits, the queue and the
// output stage; a new message may follow at once after the last byte
// when the receiver stalls the output holds its character, the queue fills
// and full goes high until characters are popped again
`default_nettype none

module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_message,
    input  wire logic       push,
    output logic            full,
    output logic [6:0]      code_char,
    output logic            last_char,
    output logic            empty,
    input  wire logic       pop
);

    `include "base64_stream_encoder_assert.svh"

    job_t front_job;
    job_t head_job;
    logic accept;
    logic head_valid;
    logic head_done;

    assign accept = push && !full;

    b64e_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .job            (front_job)
    );

    b64e_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (front_job),
        .full     (full),
        .rd_valid (head_valid),
        .rd_data  (head_job),
        .rd_en    (head_done)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_done  (head_done),
        .code_char (code_char),
        .last_char (last_char),
        .empty     (empty),
        .pop       (pop)
    );

    // queued jobs carry one to four characters
    `B64E_ASSERT_IMPLIES(a_job_count, head_valid,
        head_job.count == 3'd1 || head_job.count == 3'd2 || head_job.count == 3'd3 ||
        head_job.count == 3'd4)

    // a job never starts with padding
    `B64E_ASSERT_IMPLIES(a_no_lead_pad, head_valid, head_job.chars[0] != PAD_CHAR)

    // only a message's final byte emits the zero-fill symbol and padding
    `B64E_ASSERT_IMPLIES(a_mid_count, head_valid && !head_job.last,
        head_job.count == 3'd1 || head_job.count == 3'd2)

    // a finished job always leaves a character in the output stage
    `B64E_ASSERT_NEXT(a_done_shows, head_done, !empty)

endmodule

`default_nettype wire

[tb/base64_stream_encoder_tb.sv]
module base64_stream_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RANDOM_BYTES    = 436;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DIRECTED_ROWS   = 24;

    typedef struct packed {
        char_t code;
        logic  is_last;
    } coded_char_t;

    typedef struct {
        logic [7:0] data;
        logic       eom;
        string      want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_message = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [6:0] code_char;
    logic       last_char;
    logic       empty;
    logic       pop = 1'b0;

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // encoder state as seen by the predictor
    logic [3:0] carry_nibble = 4'h0;
    logic [1:0] byte_slot = 2'd0;

    coded_char_t expected_chars[$];
    coded_char_t popped_char;

    int error_count = 0;
    int chars_checked = 0;
    int bytes_sent = 0;
    int messages_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;

    // fixed expectations only where they are obvious, the rest from the predictor
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, "AA=="},
        '{8'hFF, 1'b1, "/w=="},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b1, "/8="},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b1, "//"},
        '{8'h4D, 1'b0, "T"},
        '{8'h61, 1'b0, "W"},
        '{8'h6E, 1'b1, "Fu"},
        '{8'h4D, 1'b0, "T"},
        '{8'h61, 1'b1, "WE="},
        '{8'h4D, 1'b1, "TQ=="},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b0, ""},
        '{8'h80, 1'b0, ""},
        '{8'h01, 1'b0, ""},
        '{8'hAA, 1'b0, ""},
        '{8'h55, 1'b0, ""},
        '{8'h7F, 1'b0, ""},
        '{8'hFE, 1'b1, ""},
        '{8'hFB, 1'b0, ""},
        '{8'hEF, 1'b1, ""}
    };

    base64_stream_encoder uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .push           (push),
        .full           (full),
        .code_char      (code_char),
        .last_char      (last_char),
        .empty          (empty),
        .pop            (pop)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    function automatic char_t symbol_char(input logic [5:0] sym);
        return char_t'(alphabet[sym]);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // advances the encoder state by one byte and queues the characters it yields
    task automatic encode_byte(input logic [7:0] b, input logic eom, input string want);
        char_t chars[$];
        int    i;
        case (byte_slot)
            2'd1:
            begin
                chars.push_back(symbol_char({carry_nibble[1:0], b[7:4]}));
                carry_nibble = b[3:0];
                byte_slot    = 2'd2;
            end
            2'd2:
            begin
                chars.push_back(symbol_char({carry_nibble, b[7:6]}));
                chars.push_back(symbol_char(b[5:0]));
                carry_nibble = 4'h0;
                byte_slot    = 2'd0;
            end
            default:
            begin
                chars.push_back(symbol_char(b[7:2]));
                carry_nibble = {2'b00, b[1:0]};
                byte_slot    = 2'd1;
            end
        endcase
        if (eom)
        begin
            if (byte_slot == 2'd1)
            begin
                chars.push_back(symbol_char({carry_nibble[1:0], 4'h0}));
                chars.push_back(PAD_CHAR);
                chars.push_back(PAD_CHAR);
            end
            else if (byte_slot == 2'd2)
            begin
                chars.push_back(symbol_char({carry_nibble, 2'b00}));
                chars.push_back(PAD_CHAR);
            end
            carry_nibble = 4'h0;
            byte_slot    = 2'd0;
        end
        if (want.len() != 0)
        begin
            chars.delete();
            for (i = 0; i < want.len(); i++)
            begin
                chars.push_back(char_t'(want[i]));
            end
        end
        for (i = 0; i < chars.size(); i++)
        begin
            expected_chars.push_back('{chars[i], eom && (i == chars.size() - 1)});
        end
    endtask

    // offers one byte, with random gaps between bursts, and waits until it is taken
    task automatic offer_byte(input logic [7:0] b, input logic eom, input string want);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        data_byte      <= b;
        end_of_message <= eom;
        push           <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        burst_left--;
        bytes_sent++;
        if (eom)
        begin
            messages_sent++;
        end
        encode_byte(b, eom, want);
    endtask

    // result side: compare every popped character with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character %0d", code_char));
            end
            else
            begin
                popped_char = expected_chars.pop_front();
                chars_checked++;
                if (code_char !== popped_char.code)
                begin
                    report_mismatch($sformatf("code_char %0d, expected %0d",
                        code_char, popped_char.code));
                end
                if (last_char !== popped_char.is_last)
                begin
                    report_mismatch($sformatf("last_char %0b, expected %0b",
                        last_char, popped_char.is_last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[base64_stream_encoder] ERROR");
            $finish;
        end
    end

    // receiver: stall pattern reloaded now and then, plus one long hold-off
    initial
    begin
        logic [15:0] stall_mask;
        bit          hold_done;
        int          k;
        stall_mask = 16'hFFFF;
        hold_done  = 1'b0;
        k          = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && bytes_sent >= 120)
            begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (k % 48 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_mask = 16'hFFFF;
                        1: stall_mask = 16'($urandom);
                        2: stall_mask = 16'($urandom | $urandom);
                        default: stall_mask = 16'($urandom & $urandom) | 16'h0101;
                    endcase
                end
                pop <= stall_mask[k % 16];
                k++;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int i;
        int msg_len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            offer_byte(directed_rows[i].data, directed_rows[i].eom, directed_rows[i].want);
        end

        while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES)
        begin
            msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 8);
            for (i = 0; i < msg_len; i++)
            begin
                offer_byte(8'($urandom_range(0, 255)), i == msg_len - 1, "");
            end
        end
        push <= 1'b0;

        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d messages sent, %0d characters checked",
            bytes_sent, messages_sent, chars_checked);
        $display("stalls and one long receiver hold-off applied, %0d mismatches",
            error_count);
        if (error_count == 0)
        begin
            $display("[base64_stream_encoder] OK");
        end
        else
        begin
            $display("[base64_stream_encoder] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
tb/base64_stream_encoder_tb.sv
